// ----- hdl/drqs_pkg.sv -----
// ----------------------------------------------------------------------------
// drqs_pkg
// Types and constants shared by the dual ready-queue scheduler modules.
// ----------------------------------------------------------------------------
package drqs_pkg;

    localparam int HANDLE_W        = 8;
    localparam int SLICE_W         = 16;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ENTRY_W         = HANDLE_W + SLICE_W;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_GET   = 2'd1,
        OP_FLUSH = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [HANDLE_W-1:0] thread_handle;
        logic [SLICE_W-1:0]  slice_length;
        logic                is_kernel;
        logic                to_front;
        logic                want_kernel;
        logic                running_is_kernel;
    } item_t;

    typedef struct packed {
        logic                found;
        logic [HANDLE_W-1:0] handle_out;
        logic                reloaded;
        logic [SLICE_W-1:0]  ticks_left;
        logic                put_dropped;
    } result_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [SLICE_W-1:0]  slice;
    } entry_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;   // take the input word this cycle
        logic finish;   // RAM read data is ready, form the get result
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic get_hit;  // presented word is a get whose queue holds a thread
        logic out_busy; // result word waits and is stalled
    } dp_status_t;

endpackage

// ----- hdl/drqs_ram.sv -----
// ----------------------------------------------------------------------------
// drqs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module drqs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                    wdata,
    input  logic                                re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                    rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/drqs_ctrl.sv -----
// ----------------------------------------------------------------------------
// drqs_ctrl
// Sequencer: accepts one word at a time and waits out the RAM read of a get.
// ----------------------------------------------------------------------------
module drqs_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  drqs_pkg::dp_status_t   status,
    output drqs_pkg::ctrl_cmd_t    cmd
);

    import drqs_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_stall = status.out_busy;
                cmd.accept = item_valid && !status.out_busy;
                if (cmd.accept && status.get_hit)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/drqs_dp.sv -----
// ----------------------------------------------------------------------------
// drqs_dp
// Datapath: ring pointers and counts, the two entry RAMs, the remaining-ticks
// register and the result register.
// ----------------------------------------------------------------------------
module drqs_dp #(
    parameter int QUEUE_DEPTH = drqs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  drqs_pkg::item_t        item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output drqs_pkg::result_t      result,
    input  drqs_pkg::ctrl_cmd_t    cmd,
    output drqs_pkg::dp_status_t   status
);

    import drqs_pkg::*;

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W:0]   DEPTH_EXT = (CNT_W + 1)'(QUEUE_DEPTH);

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] p);
        return (p == LAST_IDX) ? '0 : IDX_W'(p + 1'b1);
    endfunction

    function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] p);
        return (p == '0) ? LAST_IDX : IDX_W'(p - 1'b1);
    endfunction

    function automatic logic [IDX_W-1:0] ring_tail(input logic [IDX_W-1:0] first,
                                                   input logic [CNT_W-1:0] count);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(first) + (CNT_W + 1)'(count);
        if (sum >= DEPTH_EXT)
        begin
            sum = sum - DEPTH_EXT;
        end
        return sum[IDX_W-1:0];
    endfunction

    logic [IDX_W-1:0]   user_first_reg, user_first_next;
    logic [CNT_W-1:0]   user_count_reg, user_count_next;
    logic [IDX_W-1:0]   kernel_first_reg, kernel_first_next;
    logic [CNT_W-1:0]   kernel_count_reg, kernel_count_next;
    logic [SLICE_W-1:0] ticks_reg, ticks_next;
    logic               sel_kernel_reg, sel_kernel_next;
    logic               no_reload_reg, no_reload_next;
    logic               result_valid_reg, result_valid_next;
    result_t            result_reg, result_next;

    logic               user_we, user_re, kernel_we, kernel_re;
    logic [IDX_W-1:0]   user_waddr, user_raddr, kernel_waddr, kernel_raddr;
    entry_t             wentry, user_rentry, kernel_rentry, rentry;

    drqs_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_user_ram (
        .clk   (clk),
        .we    (user_we),
        .waddr (user_waddr),
        .wdata (wentry),
        .re    (user_re),
        .raddr (user_raddr),
        .rdata (user_rentry)
    );

    drqs_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_kernel_ram (
        .clk   (clk),
        .we    (kernel_we),
        .waddr (kernel_waddr),
        .wdata (wentry),
        .re    (kernel_re),
        .raddr (kernel_raddr),
        .rdata (kernel_rentry)
    );

    assign wentry.handle   = item.thread_handle;
    assign wentry.slice    = item.slice_length;
    assign user_raddr      = user_first_reg;
    assign kernel_raddr    = kernel_first_reg;
    assign rentry          = sel_kernel_reg ? kernel_rentry : user_rentry;

    assign status.get_hit  = (item.op == OP_GET) &&
                             (item.want_kernel ? (kernel_count_reg != '0)
                                               : (user_count_reg != '0));
    assign status.out_busy = result_valid_reg && result_stall;

    always_comb
    begin
        user_first_next   = user_first_reg;
        user_count_next   = user_count_reg;
        kernel_first_next = kernel_first_reg;
        kernel_count_next = kernel_count_reg;
        ticks_next        = ticks_reg;
        sel_kernel_next   = sel_kernel_reg;
        no_reload_next    = no_reload_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;
        user_we           = 1'b0;
        user_re           = 1'b0;
        kernel_we         = 1'b0;
        kernel_re         = 1'b0;
        user_waddr        = ring_tail(user_first_reg, user_count_reg);
        kernel_waddr      = ring_tail(kernel_first_reg, kernel_count_reg);

        if (cmd.accept)
        begin
            // direct result; a get that finds a thread overwrites it on finish
            result_next            = '0;
            result_next.ticks_left = ticks_reg;
            result_valid_next      = !status.get_hit;
            case (item.op)
                OP_PUT:
                begin
                    if (item.is_kernel)
                    begin
                        if (kernel_count_reg == FULL_CNT)
                        begin
                            result_next.put_dropped = 1'b1;
                        end
                        else
                        begin
                            kernel_we         = 1'b1;
                            kernel_count_next = CNT_W'(kernel_count_reg + 1'b1);
                        end
                    end
                    else if (user_count_reg == FULL_CNT)
                    begin
                        result_next.put_dropped = 1'b1;
                    end
                    else
                    begin
                        user_we         = 1'b1;
                        user_count_next = CNT_W'(user_count_reg + 1'b1);
                        if (item.to_front)
                        begin
                            user_waddr      = ring_prev(user_first_reg);
                            user_first_next = ring_prev(user_first_reg);
                        end
                    end
                end
                OP_GET:
                begin
                    sel_kernel_next = item.want_kernel;
                    no_reload_next  = item.running_is_kernel;
                    if (status.get_hit)
                    begin
                        if (item.want_kernel)
                        begin
                            kernel_re         = 1'b1;
                            kernel_first_next = ring_next(kernel_first_reg);
                            kernel_count_next = CNT_W'(kernel_count_reg - 1'b1);
                        end
                        else
                        begin
                            user_re         = 1'b1;
                            user_first_next = ring_next(user_first_reg);
                            user_count_next = CNT_W'(user_count_reg - 1'b1);
                        end
                    end
                end
                OP_FLUSH:
                begin
                    user_first_next   = '0;
                    user_count_next   = '0;
                    kernel_first_next = '0;
                    kernel_count_next = '0;
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.finish)
        begin
            result_next             = '0;
            result_next.found       = 1'b1;
            result_next.handle_out  = rentry.handle;
            result_next.ticks_left  = ticks_reg;
            if (!sel_kernel_reg && !no_reload_reg)
            begin
                ticks_next             = rentry.slice;
                result_next.reloaded   = 1'b1;
                result_next.ticks_left = rentry.slice;
            end
            result_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            user_first_reg   <= '0;
            user_count_reg   <= '0;
            kernel_first_reg <= '0;
            kernel_count_reg <= '0;
            ticks_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            user_first_reg   <= user_first_next;
            user_count_reg   <= user_count_next;
            kernel_first_reg <= kernel_first_next;
            kernel_count_reg <= kernel_count_next;
            ticks_reg        <= ticks_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg     <= result_next;
        sel_kernel_reg <= sel_kernel_next;
        no_reload_reg  <= no_reload_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ----- hdl/dual_ready_queue_scheduler_core.sv -----
// ----------------------------------------------------------------------------
// dual_ready_queue_scheduler_core
// Kernel FIFO and user deque of thread handles with slice reload on user get.
// ----------------------------------------------------------------------------
// One word is in work at a time. A put, a flush, a no-op and a get from an
// empty queue have their result word registered at the accepting edge. A get
// that finds a thread reads the entry RAM of the chosen queue at the accepting
// edge, and the result word forms from the registered read data at the next
// edge. A new word is taken in any idle cycle in which the result register is
// empty or its word leaves. Both queues hold QUEUE_DEPTH entries in RAM; a put
// to a full queue is dropped and flagged. Entry RAMs need no clearing after
// reset.
module dual_ready_queue_scheduler_core #(
    parameter int QUEUE_DEPTH = drqs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  drqs_pkg::item_t     item,
    output logic                result_valid,
    input  logic                result_stall,
    output drqs_pkg::result_t   result
);

    import drqs_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    drqs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    drqs_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

// ----- tb/sv/schedule_check.sv -----
// ----------------------------------------------------------------------------
// schedule_check
// Watches both channels of the scheduler core, predicts each result word
// from its own copy of the kernel FIFO, the user deque and the tick register,
// and compares every result word field by field in order of arrival.
// ----------------------------------------------------------------------------
module schedule_check
    import drqs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    input  logic    item_stall,
    input  item_t   item,
    input  logic    result_valid,
    input  logic    result_stall,
    input  result_t result,
    output int      fail_count,
    output int      words_pending
);

    localparam int DEPTH = QUEUE_DEPTH_DEF;

    entry_t               kern_ring [DEPTH];
    entry_t               user_ring [DEPTH];
    int                   kern_head;
    int                   kern_cnt;
    int                   user_head;
    int                   user_cnt;
    logic [SLICE_W-1:0]   ticks;
    result_t              awaited_results [$];
    int                   fails;

    function automatic result_t run_scheduler_op(input item_t w);
        result_t r;
        entry_t  e;
        r = '0;
        e.handle = w.thread_handle;
        e.slice  = w.slice_length;
        case (w.op)
            OP_PUT:
            begin
                if (w.is_kernel)
                begin
                    if (kern_cnt >= DEPTH)
                        r.put_dropped = 1'b1;
                    else
                    begin
                        kern_ring[(kern_head + kern_cnt) % DEPTH] = e;
                        kern_cnt++;
                    end
                end
                else if (user_cnt >= DEPTH)
                    r.put_dropped = 1'b1;
                else if (w.to_front)
                begin
                    // step the front back one slot, then store there
                    user_head = (user_head + DEPTH - 1) % DEPTH;
                    user_ring[user_head] = e;
                    user_cnt++;
                end
                else
                begin
                    user_ring[(user_head + user_cnt) % DEPTH] = e;
                    user_cnt++;
                end
            end
            OP_GET:
            begin
                if (w.want_kernel)
                begin
                    if (kern_cnt != 0)
                    begin
                        r.found      = 1'b1;
                        r.handle_out = kern_ring[kern_head].handle;
                        kern_head    = (kern_head + 1) % DEPTH;
                        kern_cnt--;
                    end
                end
                else if (user_cnt != 0)
                begin
                    r.found      = 1'b1;
                    r.handle_out = user_ring[user_head].handle;
                    // a running kernel thread keeps its tick count
                    if (!w.running_is_kernel)
                    begin
                        ticks      = user_ring[user_head].slice;
                        r.reloaded = 1'b1;
                    end
                    user_head = (user_head + 1) % DEPTH;
                    user_cnt--;
                end
            end
            OP_FLUSH:
            begin
                kern_head = 0;
                kern_cnt  = 0;
                user_head = 0;
                user_cnt  = 0;
            end
            default:
            begin
            end
        endcase
        r.ticks_left = ticks;
        return r;
    endfunction

    task automatic report_field(input string name, input int want, input int got);
        $display("%0t: mismatch on %s: expected %0d, got %0d", $time, name, want, got);
        fails++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            kern_head = 0;
            kern_cnt  = 0;
            user_head = 0;
            user_cnt  = 0;
            ticks     = '0;
            awaited_results.delete();
            fails = 0;
            fail_count    <= 0;
            words_pending <= 0;
        end
        else
        begin
            if (item_valid && !item_stall)
                awaited_results.push_back(run_scheduler_op(item));
            if (result_valid && !result_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: result word with none expected: %h", $time, result);
                    fails++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (result.found !== want.found)
                        report_field("found", want.found, result.found);
                    if (result.handle_out !== want.handle_out)
                        report_field("handle_out", want.handle_out, result.handle_out);
                    if (result.reloaded !== want.reloaded)
                        report_field("reloaded", want.reloaded, result.reloaded);
                    if (result.ticks_left !== want.ticks_left)
                        report_field("ticks_left", want.ticks_left, result.ticks_left);
                    if (result.put_dropped !== want.put_dropped)
                        report_field("put_dropped", want.put_dropped, result.put_dropped);
                end
            end
            fail_count    <= fails;
            words_pending <= awaited_results.size();
        end
    end

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and bursty random put, get, flush and no-op words into the
// scheduler core under varying sender gaps and receiver stalls; checking is
// done by schedule_check, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import drqs_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_WORDS = 184;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_stall;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;
    int      fail_count;
    int      words_pending;
    int      idle_pct     = 0;
    int      stall_pct    = 0;
    int      cycles       = 0;

    dual_ready_queue_scheduler_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    schedule_check u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .item          (item),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result        (result),
        .fail_count    (fail_count),
        .words_pending (words_pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        result_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    function automatic item_t rand_word();
        item_t w;
        w.op                = op_t'($urandom_range(3));
        w.thread_handle     = HANDLE_W'($urandom_range(255));
        w.slice_length      = SLICE_W'($urandom_range(65535));
        w.is_kernel         = 1'($urandom_range(1));
        w.to_front          = 1'($urandom_range(1));
        w.want_kernel       = 1'($urandom_range(1));
        w.running_is_kernel = 1'($urandom_range(1));
        return w;
    endfunction

    function automatic item_t make_word(input op_t op, input logic [HANDLE_W-1:0] hnd,
                                        input logic [SLICE_W-1:0] slc, input logic kern,
                                        input logic front, input logic want_k,
                                        input logic run_k);
        item_t w;
        w.op                = op;
        w.thread_handle     = hnd;
        w.slice_length      = slc;
        w.is_kernel         = kern;
        w.to_front          = front;
        w.want_kernel       = want_k;
        w.running_is_kernel = run_k;
        return w;
    endfunction

    // hold the word until it is taken; idle first at random
    task automatic send_word(input item_t w);
        while ($urandom_range(99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= w;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    initial
    begin
        item_t w;
        int    phase;
        int    sent;
        int    run_len;
        int    pick;
        int    k;
        logic  to_kernel;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct  = 15;
        stall_pct = 69;

        // empty gets, then both queues with extreme handles and slices
        send_word(make_word(OP_GET, 8'h00, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0));
        send_word(make_word(OP_GET, 8'hFF, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1));
        send_word(make_word(OP_PUT, 8'hFF, 16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b0));
        send_word(make_word(OP_PUT, 8'h00, 16'h0000, 1'b1, 1'b1, 1'b1, 1'b1));
        send_word(make_word(OP_PUT, 8'hA5, 16'h5A5A, 1'b0, 1'b0, 1'b1, 1'b0));
        send_word(make_word(OP_PUT, 8'hFF, 16'hFFFF, 1'b0, 1'b1, 1'b0, 1'b1));
        send_word(make_word(OP_PUT, 8'h5A, 16'h8001, 1'b0, 1'b1, 1'b0, 1'b0));
        send_word(make_word(OP_GET, 8'h12, 16'h3456, 1'b0, 1'b0, 1'b0, 1'b0));
        send_word(make_word(OP_GET, 8'h00, 16'h0000, 1'b1, 1'b1, 1'b0, 1'b0));
        // running kernel thread: found but no reload
        send_word(make_word(OP_GET, 8'hFF, 16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b1));
        send_word(make_word(OP_GET, 8'h00, 16'h0000, 1'b0, 1'b0, 1'b1, 1'b0));
        send_word(make_word(OP_GET, 8'h00, 16'h0000, 1'b0, 1'b0, 1'b1, 1'b0));
        send_word(make_word(OP_GET, 8'h00, 16'h0000, 1'b0, 1'b0, 1'b1, 1'b0));
        send_word(make_word(OP_PUT, 8'h00, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0));
        send_word(make_word(OP_GET, 8'hFF, 16'hFFFF, 1'b1, 1'b1, 1'b0, 1'b0));
        send_word(make_word(OP_NOP, 8'hFF, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1));
        send_word(make_word(OP_PUT, 8'h3C, 16'h00FF, 1'b0, 1'b1, 1'b0, 1'b0));
        send_word(make_word(OP_PUT, 8'hC3, 16'hFF00, 1'b1, 1'b0, 1'b0, 1'b0));
        send_word(make_word(OP_FLUSH, 8'hFF, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1));
        send_word(make_word(OP_GET, 8'h00, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0));
        send_word(make_word(OP_GET, 8'h00, 16'h0000, 1'b0, 1'b0, 1'b1, 1'b0));

        // bursts of puts or gets to one queue drive it full or empty
        for (phase = 0; phase < 3; phase++)
        begin
            idle_pct  = (phase == 0) ? 15 : (phase == 1) ? 69 : 0;
            stall_pct = (phase == 0) ? 69 : (phase == 1) ? 15 : 0;
            sent = 0;
            while (sent < PHASE_WORDS)
            begin
                run_len   = $urandom_range(20, 1);
                pick      = $urandom_range(99);
                to_kernel = 1'($urandom_range(1));
                if (pick >= 95)
                    run_len = 1;
                for (k = 0; k < run_len; k++)
                begin
                    w = rand_word();
                    w.running_is_kernel = ($urandom_range(3) == 0);
                    if (pick < 35)
                    begin
                        w.op        = OP_PUT;
                        w.is_kernel = to_kernel;
                    end
                    else if (pick < 65)
                    begin
                        w.op          = OP_GET;
                        w.want_kernel = to_kernel;
                    end
                    else if (pick < 95)
                        w.op = $urandom_range(1) ? OP_PUT : OP_GET;
                    else
                        w.op = ($urandom_range(3) == 0) ? OP_NOP : OP_FLUSH;
                    send_word(w);
                    sent++;
                end
            end
        end

        item_valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
